[hw/rtl/bsf_pkg.sv]
// bsf_pkg: types, register indexes and helpers shared by the framer modules
// no dependencies
`default_nettype none

package bsf_pkg;

  localparam int unsigned MaxRes = 4;
  localparam int unsigned ResIdxW = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegDirection = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFlagByte = 3'd1;
  localparam logic [CfgIdxW-1:0] RegEscapeByte = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFlagCode = 3'd3;
  localparam logic [CfgIdxW-1:0] RegEscapeCode = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMaxFrameLen = 3'd5;

  localparam logic DirEncode = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_end;
    logic       frame_error;
    logic       run_last;
  } out_t;

  // all results caused by one input byte
  typedef struct packed {
    out_t [MaxRes-1:0]  res;
    logic [ResIdxW-1:0] last_idx;
  } run_t;

  function automatic out_t mk_res(input logic [7:0] b, input logic valid,
                                  input logic fend, input logic ferr);
    out_t r;
    r.out_byte    = valid ? b : 8'd0;
    r.byte_valid  = valid;
    r.frame_end   = fend;
    r.frame_error = ferr;
    r.run_last    = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/byte_stuffing_framer_core.sv]
// byte_stuffing_framer_core: escape/unescape framer, top level
// uses bsf_pkg, bsf_front, bsf_queue, bsf_back
//
// input side is a queue write: an item (data_byte, frame_last) is taken on
// a clock edge with push high and full low. results come out as a queue
// read: while empty is low the oldest result is on result, and pop takes it.
// the front part classifies each byte against the frame state in the same
// cycle and writes the whole run of its results (one to four) into a
// QueueDepth-entry run queue; bytes that give no result write nothing.
// the back part hands out one result per pop from the head run.
// a byte's results are written into the run queue when the byte is accepted.
// throughput: one byte per cycle in while full is low, one result per cycle
// out while pop is high; a stuffed byte gives two results, so heavy stuffing
// is bounded by the single result port.
// if the receiver stalls, the queue fills and full rises; nothing is lost.
// reset restores the default registers (encode, flag 126, escape 125,
// codes 2 and 1, length 1024), clears the frame state and empties the queue.
// configuration writes (wr_en, wr_index, wr_data) are registered and apply to
// later bytes; writing the direction register also clears the frame state.
`default_nettype none

module byte_stuffing_framer_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         wr_en,
  input  wire logic [bsf_pkg::CfgIdxW-1:0]  wr_index,
  input  wire logic [bsf_pkg::CfgDataW-1:0] wr_data,
  input  wire logic                         push,
  output logic                              full,
  input  wire bsf_pkg::in_t                 item,
  output logic                              empty,
  input  wire logic                         pop,
  output bsf_pkg::out_t                     result
);
  import bsf_pkg::*;

  logic accept;
  logic run_push;
  run_t run;
  logic run_valid;
  run_t head;
  logic run_done;

  assign accept = push && !full;

  bsf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .accept   (accept),
    .item     (item),
    .run_push (run_push),
    .run      (run)
  );

  bsf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (run_push),
    .wr_run (run),
    .full   (full),
    .rd     (run_done),
    .valid  (run_valid),
    .head   (head)
  );

  bsf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .run_valid (run_valid),
    .head      (head),
    .run_done  (run_done),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

[hw/rtl/bsf_front.sv]
// bsf_front: configuration registers, frame state and per-byte classification
// builds one run of up to four results per request; uses bsf_pkg
`default_nettype none

module bsf_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [bsf_pkg::CfgIdxW-1:0]  wr_index,
  input  wire logic [bsf_pkg::CfgDataW-1:0] wr_data,
  input  wire logic                     accept,
  input  wire bsf_pkg::in_t             item,
  output logic                          run_push,
  output bsf_pkg::run_t                 run
);
  import bsf_pkg::*;

  logic        direction;
  logic [7:0]  flag_byte;
  logic [7:0]  escape_byte;
  logic [7:0]  flag_code;
  logic [7:0]  escape_code;
  logic [15:0] max_frame_len;

  logic        in_frame, in_frame_next;
  logic [15:0] byte_count, byte_count_next;
  logic        escape_pending, escape_pending_next;
  logic        dropping, dropping_next;

  out_t [MaxRes-1:0] res;
  logic [2:0]        n;
  logic [16:0]       cnt;
  logic [16:0]       max17;
  logic              err;
  logic [7:0]        d;
  logic              last;

  assign d     = item.data_byte;
  assign last  = item.frame_last;
  assign max17 = {1'b0, max_frame_len};

  always_comb begin
    res                 = '0;
    n                   = 3'd0;
    err                 = 1'b0;
    cnt                 = {1'b0, byte_count};
    in_frame_next       = in_frame;
    byte_count_next     = byte_count;
    escape_pending_next = escape_pending;
    dropping_next       = dropping;
    if (dropping) begin
      if (last) begin
        dropping_next = 1'b0;
        in_frame_next = 1'b0;
        byte_count_next = 16'd0;
        escape_pending_next = 1'b0;
      end
    end else begin
      if (direction == DirEncode) begin
        if (!in_frame) begin
          res[n[1:0]] = mk_res(flag_byte, 1'b1, 1'b0, 1'b0);
          n = n + 3'd1;
          cnt = 17'd1;
          in_frame_next = 1'b1;
        end
        // flag test first, so it wins when flag equals escape
        if (d == flag_byte || d == escape_byte) begin
          if (cnt + 17'd2 > max17) begin
            err = 1'b1;
          end else begin
            res[n[1:0]] = mk_res(escape_byte, 1'b1, 1'b0, 1'b0);
            n = n + 3'd1;
            res[n[1:0]] = mk_res((d == flag_byte) ? flag_code : escape_code,
                                 1'b1, 1'b0, 1'b0);
            n = n + 3'd1;
            cnt = {1'b0, 16'(cnt + 17'd2)};
          end
        end else if (cnt >= max17) begin
          err = 1'b1;
        end else begin
          res[n[1:0]] = mk_res(d, 1'b1, 1'b0, 1'b0);
          n = n + 3'd1;
          cnt = {1'b0, 16'(cnt + 17'd1)};
        end
        byte_count_next = cnt[15:0];
        if (!err && last) begin
          if (cnt >= max17) begin
            err = 1'b1;
          end else begin
            res[n[1:0]] = mk_res(flag_byte, 1'b1, 1'b1, 1'b0);
            n = n + 3'd1;
            in_frame_next = 1'b0;
            byte_count_next = 16'd0;
            escape_pending_next = 1'b0;
          end
        end
      end else begin
        cnt = {1'b0, byte_count} + 17'd1;
        in_frame_next = 1'b1;
        if (cnt >= max17) begin
          err = 1'b1;
        end else begin
          byte_count_next = cnt[15:0];
          if (escape_pending) begin
            escape_pending_next = 1'b0;
            if (d == flag_code) begin
              res[n[1:0]] = mk_res(flag_byte, 1'b1, 1'b0, 1'b0);
              n = n + 3'd1;
            end else if (d == escape_code) begin
              res[n[1:0]] = mk_res(escape_byte, 1'b1, 1'b0, 1'b0);
              n = n + 3'd1;
            end else begin
              err = 1'b1;
            end
          end else if (d == escape_byte) begin
            escape_pending_next = 1'b1;
          end else begin
            res[n[1:0]] = mk_res(d, 1'b1, 1'b0, 1'b0);
            n = n + 3'd1;
          end
        end
        if (!err && last) begin
          // lone trailing escape dropped; end on last result, or empty result
          if (n != 3'd0) begin
            res[2'(n - 3'd1)].frame_end = 1'b1;
          end else begin
            res[n[1:0]] = mk_res(8'd0, 1'b0, 1'b1, 1'b0);
            n = n + 3'd1;
          end
          in_frame_next = 1'b0;
          byte_count_next = 16'd0;
          escape_pending_next = 1'b0;
        end
      end
      if (err) begin
        res[n[1:0]] = mk_res(8'd0, 1'b0, 1'b1, 1'b1);
        n = n + 3'd1;
        in_frame_next = 1'b0;
        byte_count_next = 16'd0;
        escape_pending_next = 1'b0;
        dropping_next = !last;
      end
      if (n != 3'd0) begin
        res[2'(n - 3'd1)].run_last = 1'b1;
      end
    end
  end

  assign run.res      = res;
  assign run.last_idx = 2'(n - 3'd1);
  assign run_push     = accept && (n != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      direction     <= 1'b0;
      flag_byte     <= 8'd126;
      escape_byte   <= 8'd125;
      flag_code     <= 8'd2;
      escape_code   <= 8'd1;
      max_frame_len <= 16'd1024;
    end else if (wr_en) begin
      unique case (wr_index)
        RegDirection:   direction <= wr_data[0];
        RegFlagByte:    flag_byte <= wr_data[7:0];
        RegEscapeByte:  escape_byte <= wr_data[7:0];
        RegFlagCode:    flag_code <= wr_data[7:0];
        RegEscapeCode:  escape_code <= wr_data[7:0];
        RegMaxFrameLen: max_frame_len <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (wr_en && wr_index == RegDirection)) begin
      in_frame       <= 1'b0;
      byte_count     <= 16'd0;
      escape_pending <= 1'b0;
      dropping       <= 1'b0;
    end else if (accept) begin
      in_frame       <= in_frame_next;
      byte_count     <= byte_count_next;
      escape_pending <= escape_pending_next;
      dropping       <= dropping_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bsf_queue.sv]
// bsf_queue: short register queue of result runs between front and back
// uses bsf_pkg
`default_nettype none

module bsf_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire bsf_pkg::run_t wr_run,
  output logic               full,
  input  wire logic          rd,
  output logic               valid,
  output bsf_pkg::run_t      head
);
  import bsf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  run_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign full  = (count == FullCnt);
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];
  assign do_wr = wr && !full;
  assign do_rd = rd && valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bsf_back.sv]
// bsf_back: walks the head run of the queue and hands out one result per request
// uses bsf_pkg
`default_nettype none

module bsf_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          run_valid,
  input  wire bsf_pkg::run_t head,
  output logic               run_done,
  output logic               empty,
  input  wire logic          pop,
  output bsf_pkg::out_t      result
);
  import bsf_pkg::*;

  logic [ResIdxW-1:0] idx;
  logic               take;

  assign empty    = !run_valid;
  assign result   = head.res[idx];
  assign take     = pop && run_valid;
  assign run_done = take && (idx == head.last_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (run_done) begin
      idx <= '0;
    end else if (take) begin
      idx <= idx + ResIdxW'(1);
    end
  end

endmodule

`default_nettype wire
